@@ src/stc_pkg.sv @@
// ----------------------------------------------------------------------------
// stc_pkg
// Types and constants shared by the sliding template correlator modules.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int unsigned RING_CELLS = 64;
  localparam int unsigned RING_IDX_W = 6;
  localparam int unsigned ACC_W      = 29;
  localparam int unsigned THTW_W     = 14;
  localparam int unsigned QUOT_W     = 17;
  localparam int unsigned SCORE_W    = 18;
  localparam int unsigned APB_ADDR_W = 4;

  localparam logic [1:0] REG_TEMPLATE_HEIGHT = 2'd0;
  localparam logic [1:0] REG_TEMPLATE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_ALIGN,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } stc_state_t;

  typedef struct packed {
    logic                     start;
    logic signed [ACC_W-1:0]  raw;
    logic [THTW_W-1:0]        thtw;
  } stc_div_req_t;

  typedef struct packed {
    logic                       busy;
    logic signed [SCORE_W-1:0]  score;
  } stc_div_rsp_t;

endpackage

@@ src/stc_ram.sv @@
// ----------------------------------------------------------------------------
// stc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/stc_cell.sv @@
// ----------------------------------------------------------------------------
// stc_cell
// One accumulator cell of the offset ring; takes its neighbor's sum on shift.
// ----------------------------------------------------------------------------
module stc_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              shift,
  input  logic signed [stc_pkg::ACC_W-1:0]  din,
  input  logic signed [stc_pkg::ACC_W-1:0]  addend,
  output logic signed [stc_pkg::ACC_W-1:0]  acc
);
  import stc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (shift) begin
      acc <= din + addend;
    end
  end

endmodule

@@ src/stc_div.sv @@
// ----------------------------------------------------------------------------
// stc_div
// Restoring divider for the score: |raw|*4 / (th*tw), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module stc_div (
  input  logic                 clk,
  input  logic                 rst,
  input  stc_pkg::stc_div_req_t req,
  output stc_pkg::stc_div_rsp_t rsp
);
  import stc_pkg::*;

  localparam int unsigned DVD_W = ACC_W + 2;

  logic                  busy;
  logic [4:0]            cnt;
  logic [DVD_W-1:0]      rem;
  logic [DVD_W-1:0]      dvs;
  logic [QUOT_W-1:0]     quo;
  logic                  sat;
  logic                  neg;
  logic [ACC_W-1:0]      mag;
  logic [DVD_W-1:0]      dvd;
  logic [QUOT_W-1:0]     qs;

  assign mag = req.raw[ACC_W-1] ? ACC_W'(-req.raw) : ACC_W'(req.raw);
  assign dvd = {mag, 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= 5'd16;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= dvd;
      dvs <= DVD_W'(req.thtw) << 16;
      quo <= '0;
      sat <= dvd >= (DVD_W'(req.thtw) << 17);
      neg <= req.raw[ACC_W-1];
    end else if (busy) begin
      if (rem >= dvs) begin
        rem <= rem - dvs;
        quo <= {quo[QUOT_W-2:0], 1'b1};
      end else begin
        quo <= {quo[QUOT_W-2:0], 1'b0};
      end
      dvs <= dvs >> 1;
    end
  end

  assign qs        = (sat || quo > QUOT_W'(65536)) ? QUOT_W'(65536) : quo;
  assign rsp.busy  = busy;
  assign rsp.score = neg ? -SCORE_W'(qs) : SCORE_W'(qs);

endmodule

@@ src/sliding_template_correlator.sv @@
// ----------------------------------------------------------------------------
// sliding_template_correlator
// Sliding cross-correlation of a stored template against an image strip.
// ----------------------------------------------------------------------------
// Template beats (kind 0) are written to the template RAM. An image beat
// (kind 1) turns the 64-cell accumulator ring through one
// full revolution while the template row is read from RAM one column a cycle,
// and each product is added as the matching offset passes the ring head.
// Each score then turns the ring until its offset is at the ring head,
// and goes on through the bit-serial divider; the scores of one edge run
// follow each other through load, divide and output. Input is taken only while idle.
module sliding_template_correlator #(
  parameter int unsigned MAX_TEMPLATE_ROWS = 128,
  parameter int unsigned MAX_TEMPLATE_COLS = 64,
  parameter int unsigned MAX_IMAGE_COLS    = 4096
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [stc_pkg::APB_ADDR_W-1:0]          paddr,
  input  logic [31:0]                             pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    kind,
  input  logic [7:0]                              pixel,
  input  logic [6:0]                              row,
  input  logic [11:0]                             column,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [11:0]                             offset,
  output logic signed [stc_pkg::ACC_W-1:0]        raw_sum,
  output logic signed [stc_pkg::SCORE_W-1:0]      score,
  output logic                                    final_of_run
);
  import stc_pkg::*;

  localparam int unsigned MEM_DEPTH = MAX_TEMPLATE_ROWS * MAX_TEMPLATE_COLS;
  localparam int unsigned AW        = MEM_DEPTH > 1 ? $clog2(MEM_DEPTH) : 1;

  // configuration
  logic [7:0]  th_reg;
  logic [6:0]  tw_reg;
  logic [12:0] iw_reg;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      th_reg <= 8'd128;
      tw_reg <= 7'd32;
      iw_reg <= 13'd512;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_TEMPLATE_HEIGHT: th_reg <= pwdata[7:0];
        REG_TEMPLATE_WIDTH:  tw_reg <= pwdata[6:0];
        REG_IMAGE_WIDTH:     iw_reg <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TEMPLATE_HEIGHT: prdata = {24'd0, th_reg};
      REG_TEMPLATE_WIDTH:  prdata = {25'd0, tw_reg};
      REG_IMAGE_WIDTH:     prdata = {19'd0, iw_reg};
      default:             prdata = '0;
    endcase
  end

  // effective sizes
  logic [7:0]  th_eff;
  logic [6:0]  tw_eff;
  logic [16:0] iw_eff;

  always_comb begin
    th_eff = th_reg;
    if (th_eff == 8'd0) th_eff = 8'd1;
    if (9'(th_eff) > 9'(MAX_TEMPLATE_ROWS)) th_eff = 8'(MAX_TEMPLATE_ROWS);
    tw_eff = tw_reg;
    if (tw_eff == 7'd0) tw_eff = 7'd1;
    if (tw_eff > 7'(MAX_TEMPLATE_COLS)) tw_eff = 7'(MAX_TEMPLATE_COLS);
    iw_eff = 17'(iw_reg);
    if (iw_eff < 17'(tw_eff)) iw_eff = 17'(tw_eff);
    if (iw_eff > 17'(MAX_IMAGE_COLS)) iw_eff = 17'(MAX_IMAGE_COLS);
  end

  // state
  stc_state_t state;
  stc_state_t state_next;

  logic        in_acc;
  logic        pix_ok;
  logic        is_end;
  logic        is_run;
  logic [11:0] o_first;
  logic [6:0]  n_first;

  logic [6:0]  cur_row;
  logic [11:0] cur_col;
  logic signed [8:0] cur_pc;
  logic [6:0]  cur_n;
  logic        cur_end;
  logic [11:0] o_cur;
  logic [11:0] o_last;
  logic [THTW_W-1:0] thtw;
  logic [6:0]  k;
  logic [RING_IDX_W-1:0] hp;

  assign in_acc  = in_valid && !in_stall;
  assign pix_ok  = 8'(row) < th_eff && 17'(column) < iw_eff;
  assign is_end  = 8'(row) == th_eff - 8'd1 && 13'(column) + 13'd1 >= 13'(tw_eff);
  assign is_run  = 17'(column) == iw_eff - 17'd1;
  assign o_first = 12'(13'(column) + 13'd1 - 13'(tw_eff));
  assign n_first = (13'(column) + 13'd1 < 13'(tw_eff)) ? 7'(column + 12'd1) : tw_eff;

  // template RAM
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic [RING_IDX_W-1:0] rd_c;
  logic          rd_use;

  assign mem_we    = in_acc && !kind && 9'(row) < 9'(MAX_TEMPLATE_ROWS)
                     && column < 12'(MAX_TEMPLATE_COLS);
  assign mem_waddr = AW'(32'(row) * 32'(MAX_TEMPLATE_COLS) + 32'(column));
  assign rd_c      = cur_col[RING_IDX_W-1:0] - hp - k[RING_IDX_W-1:0];
  assign rd_use    = k < 7'd64 && 7'(rd_c) < cur_n;
  assign mem_raddr = AW'(32'(cur_row) * 32'(MAX_TEMPLATE_COLS) + 32'(rd_c));

  stc_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_tmpl (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (pixel),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // read / multiply pipeline
  logic s1_v, s1_use, s2_v;
  logic signed [ACC_W-1:0] prod;
  logic signed [8:0] tc;

  assign tc = $signed({1'b0, mem_rdata}) - 9'sd127;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= state == ST_SWEEP && k < 7'd64;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_use <= rd_use;
    prod   <= s1_use ? ACC_W'(tc * cur_pc) : '0;
  end

  // accumulator ring
  logic ring_shift;
  logic ring_clear;
  logic signed [ACC_W-1:0] acc [RING_CELLS];
  logic signed [ACC_W-1:0] cell_din [RING_CELLS];
  logic signed [ACC_W-1:0] cell_add [RING_CELLS];

  for (genvar i = 0; i < RING_CELLS; i++) begin : g_ring
    if (i == RING_CELLS - 1) begin : g_tail
      assign cell_din[i] = ring_clear ? '0 : acc[0];
      assign cell_add[i] = (state == ST_SWEEP) ? prod : '0;
    end else begin : g_body
      assign cell_din[i] = acc[i+1];
      assign cell_add[i] = '0;
    end
    stc_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (ring_shift),
      .din    (cell_din[i]),
      .addend (cell_add[i]),
      .acc    (acc[i])
    );
  end

  // divider
  stc_div_req_t div_req;
  stc_div_rsp_t div_rsp;
  logic         div_start;

  assign div_req.start = div_start;
  assign div_req.raw   = acc[0];
  assign div_req.thtw  = thtw;

  stc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic out_load;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && kind && pix_ok) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (k == 7'd65) state_next = cur_end ? ST_ALIGN : ST_IDLE;
      end
      ST_ALIGN: begin
        if (hp == o_cur[RING_IDX_W-1:0]) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (!div_rsp.busy) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = (o_cur == o_last) ? ST_IDLE : ST_LOAD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall   = 1'b1;
    ring_shift = 1'b0;
    ring_clear = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_SWEEP: ring_shift = s2_v;
      ST_ALIGN: ring_shift = hp != o_cur[RING_IDX_W-1:0];
      ST_LOAD: begin
        ring_shift = 1'b1;
        ring_clear = 1'b1;
        div_start  = 1'b1;
      end
      ST_OUT:   out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
      hp    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SWEEP) begin
        k <= k + 7'd1;
      end else begin
        k <= '0;
      end
      if (ring_shift && state != ST_SWEEP) begin
        hp <= hp + RING_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && kind && pix_ok) begin
      cur_row <= row;
      cur_col <= column;
      cur_pc  <= $signed({1'b0, pixel}) - 9'sd127;
      cur_n   <= n_first;
      cur_end <= is_end;
      o_cur   <= o_first;
      o_last  <= is_run ? column : o_first;
      thtw    <= THTW_W'(th_eff * tw_eff);
    end else if (out_load && o_cur != o_last) begin
      o_cur <= o_cur + 12'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  logic signed [ACC_W-1:0] raw_hold;

  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      raw_hold <= acc[0];
    end
    if (out_load) begin
      offset       <= o_cur;
      raw_sum      <= raw_hold;
      score        <= div_rsp.score;
      final_of_run <= o_cur == o_last;
    end
  end

endmodule

@@ test/sliding_template_correlator_tb.sv @@
// ----------------------------------------------------------------------------
// sliding_template_correlator_tb
// Self-checking bench: templates and image strips are streamed with random
// gaps and backpressure, and every score is compared with a local predictor.
// ----------------------------------------------------------------------------
module sliding_template_correlator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stc_pkg::*;

  localparam logic KIND_TEMPLATE = 1'b0;
  localparam logic KIND_IMAGE    = 1'b1;
  localparam int   STALL_LIMIT   = 8000;
  localparam int   SETTLE_CYCLES = 300;

  typedef struct {
    logic [11:0] offset;
    logic [28:0] raw_sum;
    logic [17:0] score;
    logic        final_of_run;
  } score_t;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid, in_stall;
  logic        kind;
  logic [7:0]  pixel;
  logic [6:0]  row;
  logic [11:0] column;
  logic        out_valid, out_stall;
  logic [11:0] offset;
  logic signed [ACC_W-1:0]   raw_sum;
  logic signed [SCORE_W-1:0] score;
  logic        final_of_run;

  score_t      expected_scores[$];
  logic [7:0]  tmpl_mem[0:8191];
  bit          tmpl_written[0:8191];
  logic [28:0] ring_acc[0:63];
  logic [7:0]  th_reg;
  logic [6:0]  tw_reg;
  logic [12:0] iw_reg;
  int          errors;
  int          idle_cycles;
  int          random_beats;
  bit          no_gaps;
  bit          hold_req;
  bit          out_fast;

  sliding_template_correlator DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .pixel(pixel), .row(row), .column(column),
    .out_valid(out_valid), .out_stall(out_stall),
    .offset(offset), .raw_sum(raw_sum), .score(score), .final_of_run(final_of_run)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int eff_th();
    return (th_reg == 0) ? 1 : ((th_reg > 128) ? 128 : int'(th_reg));
  endfunction

  function automatic int eff_tw();
    return (tw_reg == 0) ? 1 : ((tw_reg > 64) ? 64 : int'(tw_reg));
  endfunction

  function automatic int eff_iw();
    int v;
    v = int'(iw_reg);
    if (v < eff_tw()) v = eff_tw();
    if (v > 4096) v = 4096;
    return v;
  endfunction

  function automatic logic [7:0] rand_pix();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom);
  endfunction

  task automatic push_score(int o, int thtw, bit last);
    score_t s;
    longint sv, mag, q;
    s.offset = 12'(o);
    s.raw_sum = ring_acc[o & 63];
    sv = longint'($signed(s.raw_sum));
    mag = (sv < 0) ? -sv : sv;
    q = (mag * 4) / thtw;
    if (q > 65536) q = 65536;
    if (sv < 0) q = -q;
    s.score = 18'(q);
    s.final_of_run = last;
    expected_scores.insert(expected_scores.size(), s);
    ring_acc[o & 63] = '0;
  endtask

  task automatic predict_beat(logic k, logic [7:0] p, logic [6:0] r, logic [11:0] c);
    int th, tw, iw, pc, tc, col;
    th = eff_th();
    tw = eff_tw();
    iw = eff_iw();
    col = int'(c);
    if (k == KIND_TEMPLATE) begin
      if (col < 64) tmpl_mem[int'(r) * 64 + col] = p;
      return;
    end
    if (int'(r) >= th || col >= iw) return;
    pc = int'(p) - 127;
    for (int i = 0; i < tw && i <= col; i++) begin
      tc = int'(tmpl_mem[int'(r) * 64 + i]) - 127;
      ring_acc[(col - i) & 63] = ring_acc[(col - i) & 63] + 29'(tc * pc);
    end
    if (int'(r) != th - 1 || col + 1 < tw) return;
    if (col == iw - 1) begin
      for (int o = iw - tw; o < iw; o++) push_score(o, th * tw, o == iw - 1);
    end else begin
      push_score(col + 1 - tw, th * tw, 1'b1);
    end
  endtask

  task automatic send_beat(logic k, logic [7:0] p, logic [6:0] r, logic [11:0] c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    pixel <= p;
    row <= r;
    column <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k == KIND_TEMPLATE && c < 64) tmpl_written[int'(r) * 64 + int'(c)] = 1'b1;
    predict_beat(k, p, r, c);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TEMPLATE_HEIGHT: th_reg = val[7:0];
      REG_TEMPLATE_WIDTH:  tw_reg = val[6:0];
      REG_IMAGE_WIDTH:     iw_reg = val[12:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(int th, int tw, int iw);
    drain();
    reg_write(REG_TEMPLATE_HEIGHT, 32'(th));
    reg_write(REG_TEMPLATE_WIDTH, 32'(tw));
    reg_write(REG_IMAGE_WIDTH, 32'(iw));
  endtask

  // fill every template cell the current geometry can read
  task automatic fill_template();
    for (int r = 0; r < eff_th(); r++)
      for (int c = 0; c < eff_tw(); c++)
        if (!tmpl_written[r * 64 + c]) send_beat(KIND_TEMPLATE, rand_pix(), 7'(r), 12'(c));
  endtask

  task automatic send_noise();
    int th, iw;
    th = eff_th();
    iw = eff_iw();
    case ($urandom_range(0, 3))
      0: send_beat(KIND_TEMPLATE, rand_pix(), 7'($urandom_range(0, th - 1)),
                   12'($urandom_range(0, 4095)));
      1: if (th < 128) send_beat(KIND_IMAGE, rand_pix(), 7'($urandom_range(th, 127)),
                                 12'($urandom_range(0, iw - 1)));
      2: if (iw < 4096) send_beat(KIND_IMAGE, rand_pix(), 7'($urandom_range(0, th - 1)),
                                  12'($urandom_range(iw, 4095)));
      default: send_beat(KIND_IMAGE, rand_pix(), 7'($urandom_range(0, th - 1)),
                         12'($urandom_range(0, iw - 1)));
    endcase
    random_beats++;
  endtask

  task automatic stream_image(bit with_noise);
    for (int c = 0; c < eff_iw(); c++)
      for (int r = 0; r < eff_th(); r++) begin
        if (with_noise && $urandom_range(0, 9) == 0) send_noise();
        send_beat(KIND_IMAGE, rand_pix(), 7'(r), 12'(c));
        if (with_noise) random_beats++;
      end
  endtask

  task automatic test_small_directed();
    set_geometry(2, 3, 5);
    send_beat(KIND_TEMPLATE, 8'd255, 7'd127, 12'd4095);
    send_beat(KIND_TEMPLATE, 8'd0, 7'd0, 12'd0);
    send_beat(KIND_TEMPLATE, 8'd255, 7'd0, 12'd1);
    send_beat(KIND_TEMPLATE, 8'd0, 7'd0, 12'd2);
    send_beat(KIND_TEMPLATE, 8'd255, 7'd1, 12'd0);
    send_beat(KIND_TEMPLATE, 8'd127, 7'd1, 12'd1);
    send_beat(KIND_TEMPLATE, 8'd128, 7'd1, 12'd2);
    send_beat(KIND_IMAGE, 8'd255, 7'd2, 12'd0);
    send_beat(KIND_IMAGE, 8'd0, 7'd127, 12'd1);
    send_beat(KIND_IMAGE, 8'd0, 7'd0, 12'd4095);
    for (int c = 0; c < 5; c++) begin
      send_beat(KIND_IMAGE, (c % 2) ? 8'd0 : 8'd255, 7'd0, 12'(c));
      send_beat(KIND_IMAGE, (c % 2) ? 8'd255 : 8'd0, 7'd1, 12'(c));
    end
    send_beat(KIND_IMAGE, 8'd200, 7'd1, 12'd4);
  endtask

  task automatic test_register_extremes();
    set_geometry(0, 0, 0);
    fill_template();
    send_beat(KIND_IMAGE, 8'd255, 7'd0, 12'd0);
    set_geometry(255, 1, 1);
    send_beat(KIND_TEMPLATE, rand_pix(), 7'd126, 12'd0);
    send_beat(KIND_TEMPLATE, rand_pix(), 7'd127, 12'd0);
    send_beat(KIND_IMAGE, rand_pix(), 7'd126, 12'd0);
    send_beat(KIND_IMAGE, rand_pix(), 7'd127, 12'd0);
    set_geometry(1, 127, 64);
    fill_template();
    send_beat(KIND_IMAGE, rand_pix(), 7'd0, 12'd0);
    send_beat(KIND_IMAGE, rand_pix(), 7'd0, 12'd63);
    set_geometry(128, 64, 8191);
    set_geometry(1, 1, 4096);
    for (int i = 0; i < 6; i++)
      send_beat(KIND_IMAGE, rand_pix(), 7'd0, 12'($urandom_range(0, 4095)));
    send_beat(KIND_IMAGE, 8'd0, 7'd0, 12'd4095);
  endtask

  task automatic test_random_strips();
    while (random_beats < 130) begin
      set_geometry($urandom_range(1, 4), $urandom_range(1, 8), $urandom_range(0, 20));
      no_gaps = ($urandom_range(0, 3) == 0);
      fill_template();
      stream_image(1'b1);
      no_gaps = 1'b0;
    end
  endtask

  task automatic test_output_hold();
    set_geometry(2, 4, 12);
    fill_template();
    no_gaps = 1'b1;
    hold_req = 1'b1;
    stream_image(1'b0);
    no_gaps = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    kind <= 1'b0;
    pixel <= '0;
    row <= '0;
    column <= '0;
    errors = 0;
    random_beats = 0;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    th_reg = 8'd128;
    tw_reg = 7'd32;
    iw_reg = 13'd512;
    for (int i = 0; i < 64; i++) ring_acc[i] = '0;
    for (int i = 0; i < 8192; i++) tmpl_written[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_small_directed();
    test_register_extremes();
    test_output_hold();
    test_random_strips();
    drain();
    if (errors == 0) begin
      $display("[sliding_template_correlator] OK");
    end else begin
      $display("[sliding_template_correlator] ERROR");
    end
    $finish;
  end

  initial begin
    int n;
    score_t e;
    out_stall <= 1'b1;
    out_fast = 1'b0;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if ($urandom_range(0, 39) == 0) out_fast = !out_fast;
        n = out_fast ? 0 : $urandom_range(0, 17);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (rst) continue;
      if (expected_scores.size() == 0) begin
        $display("%0t: unexpected beat offset=%0d raw_sum=%0d score=%0d final=%0b",
                 $time, offset, raw_sum, score, final_of_run);
        errors++;
      end else begin
        e = expected_scores.pop_front();
        if (offset !== e.offset) begin
          $display("%0t: offset exp %0d got %0d", $time, e.offset, offset);
          errors++;
        end
        if (raw_sum !== e.raw_sum) begin
          $display("%0t: raw_sum exp %0d got %0d", $time, $signed(e.raw_sum), raw_sum);
          errors++;
        end
        if (score !== e.score) begin
          $display("%0t: score exp %0d got %0d", $time, $signed(e.score), score);
          errors++;
        end
        if (final_of_run !== e.final_of_run) begin
          $display("%0t: final_of_run exp %0b got %0b", $time, e.final_of_run, final_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[sliding_template_correlator] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
